// ===== src/gpci_pkg.sv =====
// ----------------------------------------------------------------------------
// gpci_pkg
// shared types, request kinds and fixed tables of the graphics pci front end
// ----------------------------------------------------------------------------
package gpci_pkg;

  // request kinds carried on the input tuser
  localparam logic [2:0] KIND_CFG_RD   = 3'd0;
  localparam logic [2:0] KIND_CFG_WR   = 3'd1;
  localparam logic [2:0] KIND_PORT_RD  = 3'd2;
  localparam logic [2:0] KIND_PORT_WR  = 3'd3;
  localparam logic [2:0] KIND_MMIO_RD  = 3'd4;
  localparam logic [2:0] KIND_MMIO_WR  = 3'd5;

  localparam int unsigned VRAM_BYTES_DEF = 4194304;

  // mmio map
  localparam logic [23:0] MMIO_BOOT_ID   = 24'h100000;
  localparam logic [23:0] MMIO_FB_CONFIG = 24'h100200;
  localparam logic [23:0] MMIO_DAC_GEN   = 24'h680600;
  localparam logic [15:0] MMIO_CFG_PAGE  = 16'h0018;
  localparam logic [7:0]  BOOT_ID_BYTE   = 8'h06;

  // indirect port addresses whose top byte is above this go to video memory, the rest to the mmio map
  localparam logic [7:0] VRAM_ADDR_TOP   = 8'h00;

  typedef struct packed {
    logic        io_decode_on;
    logic [7:0]  mmio_window_base;
    logic [7:0]  linear_window_base;
    logic [15:0] port_io_base;
    logic        rom_on;
    logic [15:0] rom_window_base;
  } cfg_status_t;

  // chip id bytes at the bottom of the mmio window
  function automatic logic [7:0] chip_id_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h11;
      2'd1: b = 8'h01;
      2'd2: b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // id bytes of the indirect port
  function automatic logic [7:0] port_id_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h65;
      2'd1: b = 8'hd0;
      2'd2: b = 8'h16;
      default: b = 8'h2b;
    endcase
    return b;
  endfunction

endpackage

// ===== src/graphics_pci_config_and_indirect_port.sv =====
// ----------------------------------------------------------------------------
// graphics_pci_config_and_indirect_port
// register front end of a pci graphics card: config space, indirect access
// port with video memory write-out, and a byte-wide mmio register map
// ----------------------------------------------------------------------------
// the result is registered and shown on the output in the cycle after its input transfer
// throughput: one item per cycle while the output is taken; the result register frees as it is taken
// all state is updated at the input transfer, the decode is single-pass
// rst (synchronous) restores the config, port and mmio registers and empties
// the result register
module graphics_pci_config_and_indirect_port
  import gpci_pkg::*;
#(
  parameter int unsigned VRAM_BYTES = VRAM_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address [23:0], wdata [55:24]
  input  logic [55:0]  s_axis_tdata,
  // kind [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_byte [7:0], vram_write_valid [8], vram_write_addr [30:9],
  // vram_write_data [62:31], io_decode_on [63], mmio_window_base [71:64],
  // linear_window_base [79:72], port_io_base [95:80], rom_on [96],
  // rom_window_base [112:97], zero fill [119:113]
  output logic [119:0] m_axis_tdata
);

  localparam logic [21:0] VRAM_MASK = 22'(VRAM_BYTES - 1);

  logic [2:0]  kind;
  logic [23:0] address;
  logic [31:0] wdata;
  logic [7:0]  p;
  logic [1:0]  lane;
  logic        accept;

  assign kind    = s_axis_tuser;
  assign address = s_axis_tdata[23:0];
  assign wdata   = s_axis_tdata[55:24];
  assign p       = address[7:0];
  assign lane    = p[1:0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept  = s_axis_tvalid && s_axis_tready;

  logic [31:0] indirect_address;
  logic [31:0] indirect_data;
  logic [31:0] framebuffer_config;
  logic [31:0] dac_general_control;

  // config space
  logic        cfg_wr_en;
  logic [7:0]  cfg_rd_off;
  logic [7:0]  cfg_rd_byte;
  cfg_status_t cfg_status;

  // mmio read path, shared by mmio reads and indirect port reads
  logic [23:0] mmio_rd_addr;
  logic [7:0]  mmio_rd_byte;

  assign cfg_wr_en = accept && (kind == KIND_CFG_WR) && (address[23:8] == 16'd0);
  assign mmio_rd_addr = (kind == KIND_MMIO_RD) ? address
                                               : indirect_address[23:0] + 24'(lane);
  assign cfg_rd_off = (kind == KIND_CFG_RD) ? p : mmio_rd_addr[7:0];

  gpci_cfg_space u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_wr_en),
    .wr_off  (p),
    .wr_byte (wdata[7:0]),
    .rd_off  (cfg_rd_off),
    .rd_byte (cfg_rd_byte),
    .status  (cfg_status)
  );

  always_comb begin
    if (mmio_rd_addr[23:2] == 22'd0) begin
      mmio_rd_byte = chip_id_byte(mmio_rd_addr[1:0]);
    end else if (mmio_rd_addr[23:8] == MMIO_CFG_PAGE) begin
      mmio_rd_byte = cfg_rd_byte;
    end else if (mmio_rd_addr == MMIO_BOOT_ID) begin
      mmio_rd_byte = BOOT_ID_BYTE;
    end else if (mmio_rd_addr[23:2] == MMIO_FB_CONFIG[23:2]) begin
      mmio_rd_byte = framebuffer_config[8*mmio_rd_addr[1:0] +: 8];
    end else if (mmio_rd_addr[23:2] == MMIO_DAC_GEN[23:2]) begin
      mmio_rd_byte = dac_general_control[8*mmio_rd_addr[1:0] +: 8];
    end else begin
      mmio_rd_byte = 8'h00;
    end
  end

  // result and state next values
  logic [7:0]  read_byte_next;
  logic        vvalid_next;
  logic [21:0] vaddr_next;
  logic [31:0] vdata_next;
  logic [31:0] indirect_address_next;
  logic [31:0] indirect_data_next;
  logic        mw_en;
  logic [23:0] mw_addr;
  logic [31:0] mw_data;

  always_comb begin
    read_byte_next        = 8'h00;
    vvalid_next           = 1'b0;
    vaddr_next            = 22'd0;
    vdata_next            = 32'd0;
    indirect_address_next = indirect_address;
    indirect_data_next    = indirect_data;
    mw_en                 = 1'b0;
    mw_addr               = address;
    mw_data               = wdata;
    case (kind)
      KIND_CFG_RD: begin
        if (address[23:8] == 16'd0) begin
          read_byte_next = cfg_rd_byte;
        end
      end
      KIND_PORT_RD: begin
        if (p inside {[8'h00:8'h03]}) begin
          read_byte_next = port_id_byte(lane);
        end else if (p inside {[8'h08:8'h0b]}) begin
          read_byte_next = mmio_rd_byte;
        end
      end
      KIND_PORT_WR: begin
        if (p inside {[8'h04:8'h07]}) begin
          indirect_address_next[8*lane +: 8] = wdata[7:0];
        end else if (p inside {[8'h08:8'h17]}) begin
          indirect_data_next[8*lane +: 8] = wdata[7:0];
          if (lane == 2'd3) begin
            if (indirect_address[31:24] == VRAM_ADDR_TOP) begin
              mw_en   = 1'b1;
              mw_addr = indirect_address[23:0];
              mw_data = indirect_data_next;
            end else begin
              // the 0x1000000 offset leaves the low 24 address bits unchanged
              vvalid_next = 1'b1;
              vaddr_next  = indirect_address[21:0] & VRAM_MASK;
              vdata_next  = indirect_data_next;
            end
          end
        end
        if (p[4]) begin
          indirect_address_next = indirect_address_next + 32'd4;
        end
      end
      KIND_MMIO_RD: read_byte_next = mmio_rd_byte;
      KIND_MMIO_WR: mw_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      indirect_address    <= 32'd0;
      indirect_data       <= 32'd0;
      framebuffer_config  <= 32'd0;
      dac_general_control <= 32'd0;
    end else if (accept) begin
      indirect_address <= indirect_address_next;
      indirect_data    <= indirect_data_next;
      if (mw_en && (mw_addr == MMIO_FB_CONFIG)) begin
        framebuffer_config <= mw_data;
      end
      if (mw_en && (mw_addr == MMIO_DAC_GEN)) begin
        dac_general_control <= mw_data;
      end
    end
  end

  // result register
  logic [7:0]  out_read_byte;
  logic        out_vvalid;
  logic [21:0] out_vaddr;
  logic [31:0] out_vdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_byte <= read_byte_next;
      out_vvalid    <= vvalid_next;
      out_vaddr     <= vaddr_next;
      out_vdata     <= vdata_next;
    end
  end

  // status fields come straight from the live registers: they only move on
  // an input transfer, which also reloads the result register
  assign m_axis_tdata = {7'd0,
                         cfg_status.rom_window_base,
                         cfg_status.rom_on,
                         cfg_status.port_io_base,
                         cfg_status.linear_window_base,
                         cfg_status.mmio_window_base,
                         cfg_status.io_decode_on,
                         out_vdata,
                         out_vaddr,
                         out_vvalid,
                         out_read_byte};

  a_vram_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_vvalid) |-> (out_vaddr == 22'd0 && out_vdata == 32'd0))
    else $error("vram fields not cleared without a vram write");

  a_vram_only_port_wr: assert property (@(posedge clk) disable iff (rst)
    (accept && kind != KIND_PORT_WR) |=> !out_vvalid)
    else $error("vram write from a non port-write item");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_addr_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_PORT_WR && p[4])
      |=> (indirect_address == $past(indirect_address) + 32'd4))
    else $error("indirect address did not advance by four");

endmodule

// ===== src/gpci_cfg_space.sv =====
// ----------------------------------------------------------------------------
// gpci_cfg_space
// pci configuration space: id bytes, masked command and status, bases, rom
// and subsystem bytes with their write alias
// ----------------------------------------------------------------------------
module gpci_cfg_space
  import gpci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [7:0]  wr_off,
  input  logic [7:0]  wr_byte,
  input  logic [7:0]  rd_off,
  output logic [7:0]  rd_byte,
  output cfg_status_t status
);

  localparam logic [7:0] OFF_VENDOR_LO  = 8'h00;
  localparam logic [7:0] OFF_VENDOR_HI  = 8'h01;
  localparam logic [7:0] OFF_DEVICE_LO  = 8'h02;
  localparam logic [7:0] OFF_DEVICE_HI  = 8'h03;
  localparam logic [7:0] OFF_COMMAND    = 8'h04;
  localparam logic [7:0] OFF_COMMAND_HI = 8'h05;
  localparam logic [7:0] OFF_STATUS_LO  = 8'h06;
  localparam logic [7:0] OFF_STATUS_HI  = 8'h07;
  localparam logic [7:0] OFF_REVISION   = 8'h08;
  localparam logic [7:0] OFF_CLASS_HI   = 8'h0b;
  localparam logic [7:0] OFF_MMIO_BASE  = 8'h13;
  localparam logic [7:0] OFF_LIN_BASE   = 8'h17;
  localparam logic [7:0] OFF_PORT_LO    = 8'h18;
  localparam logic [7:0] OFF_PORT_HI    = 8'h19;
  localparam logic [7:0] OFF_ROM_CTRL   = 8'h30;
  localparam logic [7:0] OFF_ROM_B2     = 8'h32;
  localparam logic [7:0] OFF_ROM_B3     = 8'h33;
  localparam logic [7:0] OFF_INT_PIN    = 8'h3d;
  localparam logic [7:0] OFF_MIN_GNT    = 8'h3e;
  localparam logic [7:0] OFF_MAX_LAT    = 8'h3f;
  localparam logic [7:0] OFF_SUBSYS     = 8'h2c;
  localparam logic [7:0] OFF_SUBSYS_WR  = 8'h40;

  localparam logic [7:0] CMD_MASK       = 8'h37;
  localparam logic [7:0] STAT_RD_MASK   = 8'h73;
  localparam logic [7:0] STAT_KEEP_MASK = 8'h8f;
  localparam logic [7:0] STAT_WR_MASK   = 8'h70;
  localparam logic [7:0] PORT_LO_MASK   = 8'hfc;

  logic [7:0]  command_bits;
  logic        command_high_bit;
  logic [7:0]  status_high;
  logic        io_enable_flag;
  logic [7:0]  mmio_base_byte;
  logic [7:0]  linear_base_byte;
  logic [7:0]  port_base_low;
  logic [7:0]  port_base_high;
  logic [15:0] port_base_latched;
  logic [7:0]  rom_ctrl;
  logic [7:0]  rom_b2;
  logic [7:0]  rom_b3;
  logic [7:0]  subsystem_bytes [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      command_bits       <= 8'h03;
      command_high_bit   <= 1'b0;
      status_high        <= 8'h02;
      io_enable_flag     <= 1'b1;
      mmio_base_byte     <= 8'h00;
      linear_base_byte   <= 8'h00;
      port_base_low      <= 8'h00;
      port_base_high     <= 8'h00;
      port_base_latched  <= 16'h0000;
      rom_ctrl           <= 8'h00;
      rom_b2             <= 8'h00;
      rom_b3             <= 8'h00;
      subsystem_bytes[0] <= 8'hd2;
      subsystem_bytes[1] <= 8'h12;
      subsystem_bytes[2] <= 8'h00;
      subsystem_bytes[3] <= 8'h03;
    end else if (wr_en) begin
      case (wr_off)
        OFF_COMMAND: begin
          io_enable_flag <= wr_byte[0];
          command_bits   <= wr_byte & CMD_MASK;
        end
        OFF_COMMAND_HI: command_high_bit <= wr_byte[0];
        OFF_STATUS_HI:  status_high <= (status_high & STAT_KEEP_MASK) | (wr_byte & STAT_WR_MASK);
        OFF_MMIO_BASE:  mmio_base_byte <= wr_byte;
        OFF_LIN_BASE:   linear_base_byte <= wr_byte;
        OFF_PORT_LO:    port_base_low <= wr_byte;
        OFF_PORT_HI: begin
          // latch takes the held low byte with its two low bits cleared and the new high byte
          port_base_high    <= wr_byte;
          port_base_latched <= {wr_byte, port_base_low & PORT_LO_MASK};
        end
        OFF_ROM_CTRL:   rom_ctrl <= wr_byte;
        OFF_ROM_B2:     rom_b2 <= wr_byte;
        OFF_ROM_B3:     rom_b3 <= wr_byte;
        // writes at 0x40-0x43 land on the subsystem bytes
        OFF_SUBSYS_WR, OFF_SUBSYS_WR + 8'd1, OFF_SUBSYS_WR + 8'd2, OFF_SUBSYS_WR + 8'd3:
          subsystem_bytes[wr_off[1:0]] <= wr_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rd_off)
      OFF_VENDOR_LO:  rd_byte = 8'hd2;
      OFF_VENDOR_HI:  rd_byte = 8'h12;
      OFF_DEVICE_LO:  rd_byte = 8'h18;
      OFF_DEVICE_HI:  rd_byte = 8'h00;
      OFF_COMMAND:    rd_byte = command_bits & CMD_MASK;
      OFF_COMMAND_HI: rd_byte = {7'd0, command_high_bit};
      OFF_STATUS_LO:  rd_byte = 8'h20;
      OFF_STATUS_HI:  rd_byte = status_high & STAT_RD_MASK;
      OFF_REVISION:   rd_byte = 8'h01;
      OFF_CLASS_HI:   rd_byte = 8'h03;
      OFF_MMIO_BASE:  rd_byte = mmio_base_byte;
      OFF_LIN_BASE:   rd_byte = linear_base_byte;
      OFF_PORT_LO:    rd_byte = port_base_low;
      OFF_PORT_HI:    rd_byte = port_base_high;
      OFF_SUBSYS, OFF_SUBSYS + 8'd1, OFF_SUBSYS + 8'd2, OFF_SUBSYS + 8'd3:
        rd_byte = subsystem_bytes[rd_off[1:0]];
      OFF_INT_PIN:    rd_byte = 8'h01;
      OFF_MIN_GNT:    rd_byte = 8'h03;
      OFF_MAX_LAT:    rd_byte = 8'h01;
      default:        rd_byte = 8'h00;
    endcase
  end

  assign status.io_decode_on       = io_enable_flag;
  assign status.mmio_window_base   = mmio_base_byte;
  assign status.linear_window_base = linear_base_byte;
  assign status.port_io_base       = port_base_latched;
  assign status.rom_on             = rom_ctrl[0];
  assign status.rom_window_base    = {rom_b3, rom_b2};

endmodule

// ===== tb/graphics_pci_config_and_indirect_port_tb.sv =====
// ----------------------------------------------------------------------------
// graphics_pci_config_and_indirect_port_tb
// Drives config, indirect port and mmio accesses into the register front end.
// A scoreboard predicts every result from its own copy of the card registers
// and checks each output field, under random stalls on both streams.
// ----------------------------------------------------------------------------
module graphics_pci_config_and_indirect_port_tb;
  import gpci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VRAM_SIZE   = 4194304;
  localparam logic [31:0] VRAM_BASE   = 32'h0100_0000;
  localparam int unsigned STALL_LIMIT = 500;

  // kinds with no function
  localparam logic [2:0] KIND_UNUSED6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED7 = 3'd7;

  // config space offsets
  localparam logic [23:0] CFG_ID           = 24'h00;
  localparam logic [23:0] CFG_CMD          = 24'h04;
  localparam logic [23:0] CFG_CMD_HI       = 24'h05;
  localparam logic [23:0] CFG_STAT_LO      = 24'h06;
  localparam logic [23:0] CFG_STAT_HI      = 24'h07;
  localparam logic [23:0] CFG_REV          = 24'h08;
  localparam logic [23:0] CFG_CLASS_HI     = 24'h0b;
  localparam logic [23:0] CFG_MMIO_BAR     = 24'h13;
  localparam logic [23:0] CFG_LIN_BAR      = 24'h17;
  localparam logic [23:0] CFG_PORT_LO      = 24'h18;
  localparam logic [23:0] CFG_PORT_HI      = 24'h19;
  localparam logic [23:0] CFG_SUBSYS       = 24'h2c;
  localparam logic [23:0] CFG_ROM_CTL      = 24'h30;
  localparam logic [23:0] CFG_ROM_LO       = 24'h32;
  localparam logic [23:0] CFG_ROM_HI       = 24'h33;
  localparam logic [23:0] CFG_INT_LINE     = 24'h3c;
  localparam logic [23:0] CFG_INT_PIN      = 24'h3d;
  localparam logic [23:0] CFG_MIN_GNT      = 24'h3e;
  localparam logic [23:0] CFG_MAX_LAT      = 24'h3f;
  localparam logic [23:0] CFG_SUBSYS_ALIAS = 24'h40;

  // indirect port offsets
  localparam logic [23:0] PORT_ID       = 24'h00;
  localparam logic [23:0] PORT_ADDR     = 24'h04;
  localparam logic [23:0] PORT_DATA     = 24'h08;
  localparam logic [23:0] PORT_DATA_ADV = 24'h10;

  // mmio map
  localparam logic [23:0] BOOT_ID_ADDR    = 24'h100000;
  localparam logic [23:0] FB_CONFIG_ADDR  = 24'h100200;
  localparam logic [23:0] DAC_GEN_ADDR    = 24'h680600;
  localparam logic [23:0] CFG_MIRROR_ADDR = 24'h001800;

  // laid out exactly as m_axis_tdata
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] rom_window_base;
    logic        rom_on;
    logic [15:0] port_io_base;
    logic [7:0]  linear_window_base;
    logic [7:0]  mmio_window_base;
    logic        io_decode_on;
    logic [31:0] vram_write_data;
    logic [21:0] vram_write_addr;
    logic        vram_write_valid;
    logic [7:0]  read_byte;
  } result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;   // address [23:0], wdata [55:24]
  logic [2:0]   s_axis_tuser;   // kind [2:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;   // read_byte .. rom_window_base, zero fill on top

  // predicted card registers
  logic [7:0]  cmd_reg;
  logic        cmd_hi;
  logic [7:0]  stat_hi;
  logic        io_en;
  logic [7:0]  mmio_base;
  logic [7:0]  lin_base;
  logic [7:0]  pbase_lo;
  logic [7:0]  pbase_hi;
  logic [15:0] pbase_lat;
  logic [7:0]  rom_ctl;
  logic [7:0]  rom_lo;
  logic [7:0]  rom_hi;
  logic [7:0]  subsys [4];
  logic [31:0] ind_addr;
  logic [31:0] ind_data;
  logic [31:0] fb_cfg;
  logic [31:0] dac_ctl;

  result_t     pending_results [$];
  bit          idling;
  int unsigned stall_left = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_vram     = 0;
  int unsigned n_errors   = 0;

  graphics_pci_config_and_indirect_port #(
    .VRAM_BYTES(VRAM_SIZE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] cfg_byte(input logic [23:0] off);
    logic [7:0] b;
    case (off)
      CFG_ID:          b = 8'hd2;
      CFG_ID + 24'd1:  b = 8'h12;
      CFG_ID + 24'd2:  b = 8'h18;
      CFG_ID + 24'd3:  b = 8'h00;
      CFG_CMD:         b = cmd_reg & 8'h37;
      CFG_CMD_HI:      b = {7'd0, cmd_hi};
      CFG_STAT_LO:     b = 8'h20;
      CFG_STAT_HI:     b = stat_hi & 8'h73;
      CFG_REV:         b = 8'h01;
      CFG_CLASS_HI:    b = 8'h03;
      CFG_MMIO_BAR:    b = mmio_base;
      CFG_LIN_BAR:     b = lin_base;
      CFG_PORT_LO:     b = pbase_lo;
      CFG_PORT_HI:     b = pbase_hi;
      CFG_SUBSYS, CFG_SUBSYS + 24'd1, CFG_SUBSYS + 24'd2, CFG_SUBSYS + 24'd3:
        b = subsys[off[1:0]];
      CFG_INT_PIN:     b = 8'h01;
      CFG_MIN_GNT:     b = 8'h03;
      CFG_MAX_LAT:     b = 8'h01;
      default:         b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic void cfg_store(input logic [23:0] off, input logic [7:0] v);
    case (off)
      CFG_CMD: begin
        io_en   = v[0];
        cmd_reg = v & 8'h37;
      end
      CFG_CMD_HI:   cmd_hi = v[0];
      CFG_STAT_HI:  stat_hi = (stat_hi & 8'h8f) | (v & 8'h70);
      CFG_MMIO_BAR: mmio_base = v;
      CFG_LIN_BAR:  lin_base = v;
      CFG_PORT_LO:  pbase_lo = v;
      CFG_PORT_HI: begin
        // the base only latches here, from the held low byte with its two low bits cleared
        pbase_hi  = v;
        pbase_lat = {v, pbase_lo & 8'hfc};
      end
      CFG_ROM_CTL:  rom_ctl = v;
      CFG_ROM_LO:   rom_lo = v;
      CFG_ROM_HI:   rom_hi = v;
      CFG_SUBSYS_ALIAS, CFG_SUBSYS_ALIAS + 24'd1, CFG_SUBSYS_ALIAS + 24'd2,
      CFG_SUBSYS_ALIAS + 24'd3:
        subsys[off[1:0]] = v;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] mmio_byte(input logic [23:0] a);
    logic [7:0] b;
    if (a <= 24'd3) begin
      case (a[1:0])
        2'd0:    b = 8'h11;
        2'd1:    b = 8'h01;
        2'd2:    b = 8'h03;
        default: b = 8'h00;
      endcase
    end else if (a[23:8] == CFG_MIRROR_ADDR[23:8]) begin
      b = cfg_byte({16'd0, a[7:0]});
    end else if (a == BOOT_ID_ADDR) begin
      b = 8'h06;
    end else if (a[23:2] == FB_CONFIG_ADDR[23:2]) begin
      b = fb_cfg[8*a[1:0] +: 8];
    end else if (a[23:2] == DAC_GEN_ADDR[23:2]) begin
      b = dac_ctl[8*a[1:0] +: 8];
    end else begin
      b = 8'h00;
    end
    return b;
  endfunction

  function automatic void mmio_store(input logic [23:0] a, input logic [31:0] v);
    if (a == FB_CONFIG_ADDR)
      fb_cfg = v;
    else if (a == DAC_GEN_ADDR)
      dac_ctl = v;
  endfunction

  function automatic result_t predict_access(input logic [2:0] kind, input logic [23:0] addr,
                                             input logic [31:0] wdata);
    result_t     r;
    logic [7:0]  p;
    logic [31:0] vram_off;
    r = '0;
    p = addr[7:0];
    case (kind)
      KIND_CFG_RD: r.read_byte = cfg_byte(addr);
      KIND_CFG_WR: cfg_store(addr, wdata[7:0]);
      KIND_PORT_RD: begin
        if (p <= 8'h03) begin
          case (p[1:0])
            2'd0:    r.read_byte = 8'h65;
            2'd1:    r.read_byte = 8'hd0;
            2'd2:    r.read_byte = 8'h16;
            default: r.read_byte = 8'h2b;
          endcase
        end else if (p >= 8'h08 && p <= 8'h0b) begin
          // lane offset wraps within 24 bits
          r.read_byte = mmio_byte(ind_addr[23:0] + {22'd0, p[1:0]});
        end
      end
      KIND_PORT_WR: begin
        if (p >= 8'h04 && p <= 8'h07) begin
          ind_addr[8*p[1:0] +: 8] = wdata[7:0];
        end else if (p >= 8'h08 && p <= 8'h17) begin
          ind_data[8*p[1:0] +: 8] = wdata[7:0];
          if (p[1:0] == 2'd3) begin
            if (ind_addr < VRAM_BASE) begin
              mmio_store(ind_addr[23:0], ind_data);
            end else begin
              vram_off             = (ind_addr - VRAM_BASE) & (VRAM_SIZE - 1);
              r.vram_write_valid   = 1'b1;
              r.vram_write_addr    = vram_off[21:0];
              r.vram_write_data    = ind_data;
            end
          end
        end
        if (p[4])
          ind_addr = ind_addr + 32'd4;
      end
      KIND_MMIO_RD: r.read_byte = mmio_byte(addr);
      KIND_MMIO_WR: mmio_store(addr, wdata);
      default: ;
    endcase
    r.io_decode_on       = io_en;
    r.mmio_window_base   = mmio_base;
    r.linear_window_base = lin_base;
    r.port_io_base       = pbase_lat;
    r.rom_on             = rom_ctl[0];
    r.rom_window_base    = {rom_hi, rom_lo};
    return r;
  endfunction

  // --------------------------------------------------------------- scoreboard

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 10)
        $display("result %0d: %s expected %0h, got %0h", n_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    if (!rst) begin
      // pop before push: a result can never belong to the transfer of this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_checked++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d arrived with nothing outstanding: %h", n_checked,
                     m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
          check_field("vram_write_valid", 32'(want.vram_write_valid),
                      32'(got.vram_write_valid));
          check_field("vram_write_addr", 32'(want.vram_write_addr),
                      32'(got.vram_write_addr));
          check_field("vram_write_data", want.vram_write_data, got.vram_write_data);
          check_field("io_decode_on", 32'(want.io_decode_on), 32'(got.io_decode_on));
          check_field("mmio_window_base", 32'(want.mmio_window_base),
                      32'(got.mmio_window_base));
          check_field("linear_window_base", 32'(want.linear_window_base),
                      32'(got.linear_window_base));
          check_field("port_io_base", 32'(want.port_io_base), 32'(got.port_io_base));
          check_field("rom_on", 32'(want.rom_on), 32'(got.rom_on));
          check_field("rom_window_base", 32'(want.rom_window_base),
                      32'(got.rom_window_base));
          check_field("zero fill", 32'(want.pad), 32'(got.pad));
          if (got.vram_write_valid === 1'b1)
            n_vram++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(predict_access(s_axis_tuser, s_axis_tdata[23:0],
                                                 s_axis_tdata[55:24]));
        n_accepted++;
      end
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1)
        m_axis_tready <= 1'b1;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(1, 13);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no transfer on either stream for %0d cycles", STALL_LIMIT);
    $display("** graphics_pci_config_and_indirect_port: FAILED **");
    $finish;
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_item(input logic [2:0] kind, input logic [23:0] addr,
                           input logic [31:0] data);
    int unsigned gap;
    if (idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // random upper bits, given low byte
  function automatic logic [31:0] byte_word(input logic [7:0] b);
    logic [31:0] w;
    w = $urandom();
    w[7:0] = b;
    return w;
  endfunction

  function automatic logic [23:0] pick_cfg_reg();
    case ($urandom_range(0, 10))
      0:       return CFG_CMD;
      1:       return CFG_CMD_HI;
      2:       return CFG_STAT_HI;
      3:       return CFG_MMIO_BAR;
      4:       return CFG_LIN_BAR;
      5:       return CFG_PORT_LO;
      6:       return CFG_PORT_HI;
      7:       return CFG_ROM_CTL;
      8:       return CFG_ROM_LO;
      9:       return CFG_ROM_HI;
      default: return CFG_SUBSYS_ALIAS + 24'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [23:0] pick_mmio_addr();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0:       return 24'($urandom_range(0, 3));
      1:       return CFG_MIRROR_ADDR + 24'($urandom_range(0, 8'hff));
      2:       return BOOT_ID_ADDR;
      3:       return FB_CONFIG_ADDR + 24'($urandom_range(0, 4));
      4:       return DAC_GEN_ADDR + 24'($urandom_range(0, 4));
      5:       return 24'hffffff - 24'($urandom_range(0, 3));
      default: return r[23:0];
    endcase
  endfunction

  function automatic logic [23:0] pick_addr(input logic [2:0] kind);
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 9) == 0)
      return r[23:0];
    case (kind)
      KIND_CFG_RD, KIND_CFG_WR:
        return ($urandom_range(0, 2) == 0) ? pick_cfg_reg()
                                           : 24'($urandom_range(0, 8'h4f));
      KIND_PORT_RD, KIND_PORT_WR:
        return 24'($urandom_range(0, 8'h1f));
      default:
        return pick_mmio_addr();
    endcase
  endfunction

  function automatic logic [31:0] pick_indirect_target();
    case ($urandom_range(0, 5))
      0, 1:    return {8'h00, pick_mmio_addr()};
      2, 3:    return $urandom();
      4:       return 32'h00ff_fffc + $urandom_range(0, 8);  // either side of vram base
      default: return 32'hffff_fff8 + $urandom_range(0, 7);  // wraps on advance
    endcase
  endfunction

  task automatic port_sequence();
    logic [31:0] target;
    int          lanes;
    int          reps;
    target = pick_indirect_target();
    // mostly a full address, now and then only the low lanes
    lanes = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 4;
    for (int i = 0; i < lanes; i++)
      send_item(KIND_PORT_WR, PORT_ADDR + 24'(i), byte_word(target[8*i +: 8]));
    case ($urandom_range(0, 4))
      0: begin
        for (int i = 0; i < 4; i++)
          send_item(KIND_PORT_WR, PORT_DATA + 24'(i), byte_word(8'($urandom())));
      end
      1: begin
        // burst: lane 3 through the advancing window
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          for (int i = 0; i < 3; i++)
            send_item(KIND_PORT_WR, PORT_DATA + 24'(i), byte_word(8'($urandom())));
          send_item(KIND_PORT_WR, PORT_DATA_ADV + 24'd3, byte_word(8'($urandom())));
        end
      end
      2: begin
        for (int i = 0; i < 4; i++)
          send_item(KIND_PORT_RD, PORT_DATA + 24'(i), rand_word());
        if ($urandom_range(0, 2) == 0)
          send_item(KIND_PORT_RD, PORT_ID + 24'($urandom_range(0, 3)), rand_word());
      end
      3: begin
        for (int i = 0; i < 4; i++)
          send_item(KIND_PORT_WR, PORT_DATA + 24'(i), byte_word(8'($urandom())));
        for (int i = 0; i < 4; i++)
          send_item(KIND_PORT_RD, PORT_DATA + 24'(i), rand_word());
      end
      default: begin
        reps = $urandom_range(1, 6);
        repeat (reps)
          send_item($urandom_range(0, 1) ? KIND_PORT_WR : KIND_PORT_RD,
                    24'($urandom_range(0, 8'h1f)), rand_word());
      end
    endcase
    if ($urandom_range(0, 6) == 0)
      send_item($urandom_range(0, 1) ? KIND_PORT_WR : KIND_PORT_RD, pick_addr(KIND_MMIO_RD),
                rand_word());
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_directed_config_space();
    send_item(KIND_CFG_RD, CFG_ID, 32'h0);
    send_item(KIND_CFG_RD, CFG_INT_LINE, 32'hffff_ffff);
    send_item(KIND_CFG_WR, CFG_CMD, 32'h0);
    send_item(KIND_CFG_WR, CFG_CMD, 32'hffff_ffff);
    send_item(KIND_CFG_WR, CFG_STAT_HI, 32'hffff_ffff);
    send_item(KIND_CFG_RD, CFG_STAT_HI, 32'h0);
    // offsets past the 256-byte space decode nothing
    send_item(KIND_CFG_WR, CFG_CMD + 24'h100, 32'h0);
    send_item(KIND_CFG_WR, CFG_PORT_LO, 32'hffff_ffff);
    send_item(KIND_CFG_WR, CFG_PORT_HI, 32'hffff_ffff);
    send_item(KIND_CFG_WR, CFG_ROM_CTL, 32'hffff_ffff);
    send_item(KIND_CFG_WR, CFG_ROM_HI, 32'hffff_ffff);
    send_item(KIND_CFG_WR, CFG_SUBSYS_ALIAS + 24'd3, 32'h0000_005a);
  endtask

  task automatic test_directed_indirect_port();
    for (int i = 0; i < 4; i++)
      send_item(KIND_PORT_WR, PORT_ADDR + 24'(i), 32'h0000_00ff);
    send_item(KIND_PORT_WR, PORT_DATA, 32'h0000_00a5);
    send_item(KIND_PORT_WR, PORT_DATA + 24'd1, 32'h0000_005a);
    send_item(KIND_PORT_WR, PORT_DATA + 24'd2, 32'h0000_0000);
    send_item(KIND_PORT_WR, PORT_DATA + 24'd3, 32'hffff_ffff);
    // dispatch again, then the address wraps past the top
    send_item(KIND_PORT_WR, PORT_DATA_ADV + 24'd3, 32'h0000_0081);
    send_item(KIND_PORT_RD, PORT_DATA, 32'h0);
    send_item(KIND_PORT_RD, PORT_ID + 24'd3, 32'h0);
  endtask

  task automatic test_directed_mmio_and_unused();
    send_item(KIND_MMIO_RD, CFG_MIRROR_ADDR + CFG_SUBSYS + 24'd3, 32'h0);
    send_item(KIND_MMIO_WR, FB_CONFIG_ADDR, 32'hffff_ffff);
    send_item(KIND_MMIO_RD, FB_CONFIG_ADDR + 24'd3, 32'h0);
    send_item(KIND_MMIO_WR, FB_CONFIG_ADDR + 24'd4, 32'h0);
    send_item(KIND_MMIO_RD, 24'hffffff, 32'h0);
    send_item(KIND_UNUSED6, 24'hffffff, 32'hffff_ffff);
    send_item(KIND_UNUSED7, 24'hffffff, 32'hffff_ffff);
  endtask

  task automatic test_random_config();
    logic [2:0] k;
    repeat (300) begin
      k = $urandom_range(0, 1) ? KIND_CFG_WR : KIND_CFG_RD;
      send_item(k, pick_addr(k), rand_word());
    end
  endtask

  task automatic test_random_port_sequences();
    int unsigned start;
    start = n_accepted;
    while (n_accepted - start < 500)
      port_sequence();
  endtask

  task automatic test_random_mmio();
    logic [2:0] k;
    repeat (250) begin
      k = ($urandom_range(0, 2) == 0) ? KIND_MMIO_WR : KIND_MMIO_RD;
      send_item(k, pick_addr(k), rand_word());
    end
  endtask

  task automatic test_random_mixed(input int count, input bit bursts);
    logic [2:0] k;
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idling
      if (bursts && i % 40 == 0)
        idling = ($urandom_range(0, 2) != 0);
      k = 3'($urandom_range(0, 7));
      send_item(k, pick_addr(k), rand_word());
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b1;
    idling        = 1'b0;

    cmd_reg   = 8'd3;
    cmd_hi    = 1'b0;
    stat_hi   = 8'd2;
    io_en     = 1'b1;
    mmio_base = 8'd0;
    lin_base  = 8'd0;
    pbase_lo  = 8'd0;
    pbase_hi  = 8'd0;
    pbase_lat = 16'd0;
    rom_ctl   = 8'd0;
    rom_lo    = 8'd0;
    rom_hi    = 8'd0;
    subsys[0] = 8'hd2;
    subsys[1] = 8'h12;
    subsys[2] = 8'h00;
    subsys[3] = 8'h03;
    ind_addr  = 32'd0;
    ind_data  = 32'd0;
    fb_cfg    = 32'd0;
    dac_ctl   = 32'd0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idling = 1'b1;
    test_directed_config_space();
    test_directed_indirect_port();
    test_directed_mmio_and_unused();
    drain_results();

    test_random_config();
    drain_results();
    test_random_port_sequences();
    drain_results();
    test_random_mmio();
    drain_results();
    test_random_mixed(200, 1'b1);

    // tail at full rate
    idling = 1'b0;
    test_random_mixed(100, 1'b0);
    drain_results();
    repeat (4) @(posedge clk);

    $display("covered config space, indirect port sequences, mmio and unused kinds: "
             , "%0d transfers in, %0d results checked", n_accepted, n_checked);
    $display("%0d video memory writes seen, %0d failures", n_vram, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("** graphics_pci_config_and_indirect_port: PASSED **");
    end else begin
      $display("** graphics_pci_config_and_indirect_port: FAILED **");
    end
    $finish;
  end

endmodule
